// File: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types for the trial division primality tester: the control and
// status words passed between the sequencer and the remainder unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	// sequencer to remainder unit
	typedef struct packed {
		logic start;
	} rem_ctl_t;

	// remainder unit to sequencer
	typedef struct packed {
		logic done;
		logic zero;
	} rem_sts_t;

endpackage

// File: rtl/trial_division_primality_test.sv
// ----------------------------------------------------------------------------
// trial_division_primality_test
// Tests one signed word for primality by trying odd divisors from 3 upward
// while divisor squared is no greater than the value.
// ----------------------------------------------------------------------------
// Negative, zero, one, two and even values are settled from the input word
// alone. Odd values try each divisor in turn on the single radix-2
// remainder unit until one divides or divisor squared exceeds the value.
// One word at a time: busy stays high until the result strobe.
// done pulses for one cycle with is_prime; the receiver cannot stall.
// Reset clears the sequencer and the strobe; no memory needs clearing.
module trial_division_primality_test import tdpt_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          done,
	output logic                          is_prime
);

	localparam int W = VALUE_WIDTH;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BOUND,
		S_WAIT
	} state_t;

	state_t      state_q;
	logic [W-1:0] n_q;
	logic [W-1:0] d_q;
	logic [W-1:0] sq_q;
	logic         done_q;
	logic         prime_q;
	logic         rem_start_q;

	rem_ctl_t     rem_ctl;
	rem_sts_t     rem_sts;

	logic [W-1:0] uval;
	logic         small_val;
	logic         two_val;

	// quick classification of the incoming word
	always_comb begin
		uval      = $unsigned(value);
		small_val = uval[W-1] || (uval[W-1:1] == '0);
		two_val   = (uval == W'(2));
	end

	// sequencer: bound check, remainder, next odd divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			prime_q     <= 1'b0;
			rem_start_q <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			rem_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (small_val) begin
							done_q  <= 1'b1;
							prime_q <= 1'b0;
						end else if (two_val) begin
							done_q  <= 1'b1;
							prime_q <= 1'b1;
						end else if (!uval[0]) begin
							done_q  <= 1'b1;
							prime_q <= 1'b0;
						end else begin
							state_q <= S_BOUND;
						end
					end
				end
				S_BOUND: begin
					if (sq_q > n_q) begin
						done_q  <= 1'b1;
						prime_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						rem_start_q <= 1'b1;
						state_q     <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (rem_sts.done) begin
						if (rem_sts.zero) begin
							done_q  <= 1'b1;
							prime_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_BOUND;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// value, divisor and divisor squared; (d+2)^2 = d^2 + 4d + 4
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			n_q  <= uval;
			d_q  <= W'(3);
			sq_q <= W'(9);
		end else if (state_q == S_WAIT && rem_sts.done && !rem_sts.zero) begin
			d_q  <= d_q + W'(2);
			sq_q <= sq_q + {d_q[W-3:0], 2'b00} + W'(4);
		end
	end

	assign rem_ctl.start = rem_start_q;

	tdpt_rem #(
		.WIDTH (W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rem_ctl),
		.dividend (n_q),
		.divisor  (d_q),
		.sts      (rem_sts)
	);

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign is_prime = prime_q;

endmodule

// File: rtl/tdpt_rem.sv
// ----------------------------------------------------------------------------
// tdpt_rem
// Radix-2 restoring remainder unit. One quotient bit per cycle; after the
// last dividend bit it reports whether dividend / divisor leaves no remainder.
// ----------------------------------------------------------------------------
module tdpt_rem import tdpt_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rem_ctl_t         ctl,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output rem_sts_t         sts
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] shift_q;
	logic             done_q;
	logic             zero_q;

	logic [WIDTH:0]   trial;
	logic             fits;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] rem_next;

	// shift in the next dividend bit and conditionally subtract
	always_comb begin
		trial    = {rem_q, shift_q[WIDTH-1]};
		fits     = trial >= {1'b0, divisor};
		diff     = trial - {1'b0, divisor};
		rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDTH - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
					zero_q <= (rem_next == '0);
				end
			end
		end
	end

	// partial remainder and dividend shifter
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q   <= '0;
			shift_q <= dividend;
		end else if (run_q) begin
			rem_q   <= rem_next;
			shift_q <= {shift_q[WIDTH-2:0], 1'b0};
		end
	end

	assign sts.done = done_q;
	assign sts.zero = zero_q;

endmodule
